### hw/rtl/rlt_pkg.sv
// ----------------------------------------------------------------------------
// rlt_pkg: shared types and constants of the record lock table
// Request modes, result status codes, sequencer states and field widths.
// ----------------------------------------------------------------------------
package rlt_pkg;

  localparam int HANDLE_W = 6;
  localparam int FILE_W   = 6;
  localparam int ROW_W    = 48;

  localparam int LOCK_SLOTS_DEF = 64;
  localparam int ROW_BITS_DEF   = 48;

  // Handles at or above this count are ignored.
  localparam int HANDLE_COUNT = 64;

  localparam logic [1:0] MODE_QUERY   = 2'd0;
  localparam logic [1:0] MODE_ACQUIRE = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_LOCKED = 2'd1;
  localparam logic [1:0] STATUS_FULL   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_t;

endpackage

### hw/rtl/rlt_slot_ram.sv
// ----------------------------------------------------------------------------
// rlt_slot_ram: lock slot storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rlt_slot_ram #(
  parameter int DEPTH  = rlt_pkg::LOCK_SLOTS_DEF,
  parameter int DATA_W = 13 + rlt_pkg::ROW_BITS_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/record_lock_table.sv
// A table of row locks keyed by (file, row) with an owning handle. Pulse
// start while busy is low to transfer one request; exactly one result comes
// back later as a one-cycle done strobe with status and held, and the
// receiver cannot stall it, so capture it on that cycle. Each request walks
// all LOCK_SLOTS entries through the single read port of the slot memory,
// one entry per cycle, then writes back at most once. A request with a
// handle at or above the handle count skips the walk and goes straight
// to the decide step. After reset the block clears the slot memory one
// entry per cycle, so busy stays high until every slot has been cleared.
// compat_mode may be written at any time through cfg_write/cfg_data but
// should change only while idle.
// ----------------------------------------------------------------------------
// record_lock_table: row lock table top level
// Sequencer, slot scan compare unit, decision logic and result register.
// ----------------------------------------------------------------------------
module record_lock_table #(
  parameter int LOCK_SLOTS = rlt_pkg::LOCK_SLOTS_DEF,
  parameter int ROW_BITS   = rlt_pkg::ROW_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  mode,
  input  logic [rlt_pkg::HANDLE_W-1:0] handle,
  input  logic [rlt_pkg::FILE_W-1:0]  file_id,
  input  logic [rlt_pkg::ROW_W-1:0]   row,
  input  logic                        cfg_write,
  input  logic                        cfg_data,
  output logic                        done,
  output logic [1:0]                  status,
  output logic                        held
);

  localparam int AW      = $clog2(LOCK_SLOTS);
  localparam int ENTRY_W = 1 + rlt_pkg::FILE_W + rlt_pkg::HANDLE_W + ROW_BITS;
  localparam logic [AW-1:0] LAST_SLOT = AW'(LOCK_SLOTS - 1);

  rlt_pkg::state_t state, state_next;

  logic compat_mode;

  // Captured request
  logic [1:0]                   req_mode;
  logic [rlt_pkg::HANDLE_W-1:0] req_handle;
  logic [rlt_pkg::FILE_W-1:0]   req_file;
  logic [ROW_BITS-1:0]          req_row;
  logic                         req_bad;

  // Sweep counters
  logic [AW-1:0] clr_idx;
  logic [AW-1:0] scan_idx;
  logic          chk_valid;
  logic [AW-1:0] chk_idx;

  // Scan results
  logic                         match_found;
  logic [AW-1:0]                match_idx;
  logic [rlt_pkg::HANDLE_W-1:0] match_owner;
  logic                         free_found;
  logic [AW-1:0]                free_idx;

  // Memory ports
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [ENTRY_W-1:0]  mem_wdata;
  logic [ENTRY_W-1:0]  rd_data;

  logic [1:0] dec_status;
  logic       dec_held;

  logic         accept;
  logic         handle_bad;
  logic [63:0]  row_ext;
  logic [ROW_BITS-1:0] row_key;

  // Fields of the entry coming out of the memory
  logic                         ent_valid;
  logic [rlt_pkg::FILE_W-1:0]   ent_file;
  logic [rlt_pkg::HANDLE_W-1:0] ent_owner;
  logic [ROW_BITS-1:0]          ent_row;
  logic                         ent_hit;

  assign busy    = (state != rlt_pkg::ST_IDLE);
  assign accept  = start && (state == rlt_pkg::ST_IDLE);
  assign row_ext = 64'(row);
  assign row_key = row_ext[ROW_BITS-1:0];
  assign handle_bad = (32'(handle) >= 32'(rlt_pkg::HANDLE_COUNT));

  assign ent_valid = rd_data[ENTRY_W-1];
  assign ent_file  = rd_data[ROW_BITS + rlt_pkg::HANDLE_W +: rlt_pkg::FILE_W];
  assign ent_owner = rd_data[ROW_BITS +: rlt_pkg::HANDLE_W];
  assign ent_row   = rd_data[ROW_BITS-1:0];
  // Compare unit: one stored entry against the request key per cycle
  assign ent_hit   = ent_valid && (ent_file == req_file) && (ent_row == req_row);

  rlt_slot_ram #(
    .DEPTH  (LOCK_SLOTS),
    .DATA_W (ENTRY_W)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (scan_idx),
    .rd_data (rd_data)
  );

  // Sequencer: clear sweep, idle, scan reads, drain the last read, decide
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = clr_idx;
    mem_wdata  = '0;
    dec_status = rlt_pkg::STATUS_OK;
    dec_held   = 1'b0;
    unique case (state)
      rlt_pkg::ST_CLEAR: begin
        // Write an empty entry into each slot, one per cycle
        mem_we = 1'b1;
        if (clr_idx == LAST_SLOT) begin
          state_next = rlt_pkg::ST_IDLE;
        end
      end
      rlt_pkg::ST_IDLE: begin
        if (start) begin
          state_next = handle_bad ? rlt_pkg::ST_DECIDE : rlt_pkg::ST_SCAN;
        end
      end
      rlt_pkg::ST_SCAN: begin
        if (scan_idx == LAST_SLOT) begin
          state_next = rlt_pkg::ST_DRAIN;
        end
      end
      rlt_pkg::ST_DRAIN: begin
        state_next = rlt_pkg::ST_DECIDE;
      end
      rlt_pkg::ST_DECIDE: begin
        state_next = rlt_pkg::ST_IDLE;
        if (!req_bad) begin
          case (req_mode)
            rlt_pkg::MODE_ACQUIRE: begin
              if (match_found) begin
                if (match_owner == req_handle) begin
                  dec_held = 1'b1;
                end else if (!compat_mode) begin
                  dec_status = rlt_pkg::STATUS_LOCKED;
                end
              end else if (free_found) begin
                // Take the lowest free slot
                mem_we    = 1'b1;
                mem_waddr = free_idx;
                mem_wdata = {1'b1, req_file, req_handle, req_row};
                dec_held  = 1'b1;
              end else begin
                dec_status = rlt_pkg::STATUS_FULL;
              end
            end
            rlt_pkg::MODE_RELEASE: begin
              if (match_found) begin
                if ((match_owner == req_handle) || compat_mode) begin
                  // Drop the lock: the valid bit goes low
                  mem_we    = 1'b1;
                  mem_waddr = match_idx;
                  mem_wdata = '0;
                end else begin
                  dec_status = rlt_pkg::STATUS_LOCKED;
                end
              end
            end
            default: begin
              // Query, and the unused mode code behaves the same
              dec_held = match_found && (match_owner == req_handle);
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rlt_pkg::ST_CLEAR;
      compat_mode <= 1'b0;
      clr_idx     <= '0;
      scan_idx    <= '0;
      chk_valid   <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      done        <= 1'b0;
    end else begin
      state     <= state_next;
      done      <= (state == rlt_pkg::ST_DECIDE);
      chk_valid <= (state == rlt_pkg::ST_SCAN);
      if (cfg_write) begin
        compat_mode <= cfg_data;
      end
      if (state == rlt_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      // Advance the read address through the table during the scan
      if (state == rlt_pkg::ST_SCAN) begin
        scan_idx <= scan_idx + 1'b1;
      end else begin
        scan_idx <= '0;
      end
      if (accept) begin
        match_found <= 1'b0;
        free_found  <= 1'b0;
      end else if (chk_valid) begin
        // Keep the first match and the lowest free slot
        if (ent_hit && !match_found) begin
          match_found <= 1'b1;
        end
        if (!ent_valid && !free_found) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    chk_idx <= scan_idx;
    if (accept) begin
      req_mode   <= mode;
      req_handle <= handle;
      req_file   <= file_id;
      req_row    <= row_key;
      req_bad    <= handle_bad;
    end
    if (chk_valid && ent_hit && !match_found) begin
      match_idx   <= chk_idx;
      match_owner <= ent_owner;
    end
    if (chk_valid && !ent_valid && !free_found) begin
      free_idx <= chk_idx;
    end
    if (state == rlt_pkg::ST_DECIDE) begin
      status <= dec_status;
      held   <= dec_held;
    end
  end

  // A result strobe only follows the decide step
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == rlt_pkg::ST_DECIDE))
    else $error("result strobe without a decide step");

  // A transferred request always makes the block busy next cycle
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request transferred but block not busy");

  // No read of the scan is still in flight when the decision is taken
  assert property (@(posedge clk) disable iff (rst)
    (state == rlt_pkg::ST_DECIDE) |-> !chk_valid)
    else $error("decide step with a pending scan read");

  // A held lock always comes with an ok status
  assert property (@(posedge clk) disable iff (rst)
    (done && held) |-> (status == rlt_pkg::STATUS_OK))
    else $error("held reported with a failing status");

endmodule

### verif/rlt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rlt_checker: scoreboard for the record lock table
// Shadows the slot table and compat mode, predicts status and held for every
// request transfer and compares each done strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module rlt_checker
  import rlt_pkg::*;
#(
  parameter int SLOTS = LOCK_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic [1:0]          mode,
  input  logic [HANDLE_W-1:0] handle,
  input  logic [FILE_W-1:0]   file_id,
  input  logic [ROW_W-1:0]    row,
  input  logic                cfg_write,
  input  logic                cfg_data,
  input  logic                done,
  input  logic [1:0]          status,
  input  logic                held,
  output int                  pending,
  output int                  fail_count,
  output int                  results_seen,
  output int                  conflicts_seen,
  output int                  full_seen,
  output int                  held_seen
);

  localparam int PRINT_CAP = 100;

  typedef struct {
    logic [1:0]          mode;
    logic [HANDLE_W-1:0] handle;
    logic [FILE_W-1:0]   file_id;
    logic [ROW_W-1:0]    row;
    logic [1:0]          status;
    logic                held;
  } lock_outcome_t;

  logic                shadow_compat;
  logic [SLOTS-1:0]    shadow_used;
  logic [FILE_W-1:0]   shadow_file  [SLOTS];
  logic [ROW_W-1:0]    shadow_row   [SLOTS];
  logic [HANDLE_W-1:0] shadow_owner [SLOTS];
  lock_outcome_t       outcome_q [$];

  int outstanding    = 0;
  int mismatch_count = 0;
  int result_count   = 0;
  int conflict_count = 0;
  int full_count     = 0;
  int held_count     = 0;

  assign pending        = outstanding;
  assign fail_count     = mismatch_count;
  assign results_seen   = result_count;
  assign conflicts_seen = conflict_count;
  assign full_seen      = full_count;
  assign held_seen      = held_count;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    // keep the log short when something goes badly wrong
    if (mismatch_count <= PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  // Apply one request to the shadow table and return the result it must give.
  function automatic lock_outcome_t resolve_lock_request(
    input logic [1:0]          req_mode,
    input logic [HANDLE_W-1:0] req_handle,
    input logic [FILE_W-1:0]   req_file,
    input logic [ROW_W-1:0]    req_row
  );
    lock_outcome_t res;
    int            hit;
    int            free_slot;
    res.mode    = req_mode;
    res.handle  = req_handle;
    res.file_id = req_file;
    res.row     = req_row;
    res.status  = STATUS_OK;
    res.held    = 1'b0;
    hit         = -1;
    free_slot   = -1;
    if (int'(req_handle) >= HANDLE_COUNT) return res;
    // first valid match wins, wherever it sits; first hole is the free slot
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_used[i]) begin
        if (hit < 0 && shadow_file[i] == req_file && shadow_row[i] == req_row) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    case (req_mode)
      MODE_ACQUIRE: begin
        if (hit >= 0) begin
          if (shadow_owner[hit] == req_handle) res.held = 1'b1;
          else if (!shadow_compat) res.status = STATUS_LOCKED;
        end else if (free_slot >= 0) begin
          shadow_used[free_slot]  = 1'b1;
          shadow_file[free_slot]  = req_file;
          shadow_row[free_slot]   = req_row;
          shadow_owner[free_slot] = req_handle;
          res.held                = 1'b1;
        end else begin
          res.status = STATUS_FULL;
        end
      end
      MODE_RELEASE: begin
        if (hit >= 0) begin
          if (shadow_owner[hit] == req_handle || shadow_compat) shadow_used[hit] = 1'b0;
          else res.status = STATUS_LOCKED;
        end
      end
      default: begin
        // query, and the unused mode code that acts as one
        if (hit >= 0 && shadow_owner[hit] == req_handle) res.held = 1'b1;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : scoreboard_step
    lock_outcome_t oldest;
    if (rst) begin
      shadow_compat = 1'b0;
      shadow_used   = '0;
      outcome_q.delete();
    end else begin
      if (done) begin
        if (outcome_q.size() == 0) begin
          report_mismatch($sformatf("result status %0d held %0d with no request outstanding",
                                    status, held));
        end else begin
          oldest = outcome_q.pop_front();
          result_count++;
          if (oldest.status == STATUS_LOCKED) conflict_count++;
          if (oldest.status == STATUS_FULL) full_count++;
          if (oldest.held) held_count++;
          if (status !== oldest.status)
            report_mismatch($sformatf("mode %0d handle %0d file %0d row %h: status %0d, want %0d",
                                      oldest.mode, oldest.handle, oldest.file_id, oldest.row,
                                      status, oldest.status));
          if (held !== oldest.held)
            report_mismatch($sformatf("mode %0d handle %0d file %0d row %h: held %0d, want %0d",
                                      oldest.mode, oldest.handle, oldest.file_id, oldest.row,
                                      held, oldest.held));
        end
      end
      if (cfg_write) shadow_compat = cfg_data;
      if (start && !busy) outcome_q.push_back(resolve_lock_request(mode, handle, file_id, row));
    end
    outstanding <= outcome_q.size();
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the record lock table
// Drives directed lock sequences and then phases of random requests on a
// shared key pool, flips compat mode between phases, and leaves all checking
// to the scoreboard beside the block.
// ----------------------------------------------------------------------------
module testbench;
  import rlt_pkg::*;

  // Mode code 3 is not used by the block; it must act as a query.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int CLK_HALF        = 4;
  localparam int STALL_LIMIT     = 1000;  // well above one request plus the longest sender gap
  localparam int GAP_MAX         = 40;
  localparam int DRAIN_CYCLES    = 80;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 135;
  localparam int KEY_POOL        = 96;
  localparam int ROW_BASES       = KEY_POOL / 2;

  // Phase kinds: how hard a phase leans toward taking or giving back locks.
  localparam int KIND_FILL     = 0;
  localparam int KIND_BALANCED = 1;
  localparam int KIND_DRAIN    = 2;

  localparam logic [ROW_W-1:0] ROW_ZERO = '0;
  localparam logic [ROW_W-1:0] ROW_ALL  = '1;
  localparam logic [ROW_W-1:0] ROW_ALT1 = 48'hAAAA_AAAA_AAAA;
  localparam logic [ROW_W-1:0] ROW_ALT0 = 48'h5555_5555_5555;
  localparam logic [HANDLE_W-1:0] HANDLE_TOP = '1;
  localparam logic [FILE_W-1:0]   FILE_TOP   = '1;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                start     = 1'b0;
  logic [1:0]          mode      = MODE_QUERY;
  logic [HANDLE_W-1:0] handle    = '0;
  logic [FILE_W-1:0]   file_id   = '0;
  logic [ROW_W-1:0]    row       = '0;
  logic                cfg_write = 1'b0;
  logic                cfg_data  = 1'b0;
  logic                busy;
  logic                done;
  logic [1:0]          status;
  logic                held;

  int pending;
  int fail_count;
  int results_seen;
  int conflicts_seen;
  int full_seen;
  int held_seen;

  // Stimulus bookkeeping for the summary.
  int  query_sent   = 0;
  int  acquire_sent = 0;
  int  release_sent = 0;
  int  unused_sent  = 0;
  int  stall_cycles = 0;
  bit  no_idle      = 1'b0;

  // Key pool: row bases under file_a, then under other files; paired rows one bit apart.
  logic [FILE_W-1:0] pool_file [KEY_POOL];
  logic [ROW_W-1:0]  pool_row  [KEY_POOL];

  always #(CLK_HALF) clk = ~clk;

  record_lock_table dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .mode      (mode),
    .handle    (handle),
    .file_id   (file_id),
    .row       (row),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .done      (done),
    .status    (status),
    .held      (held)
  );

  rlt_checker lock_check (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .handle         (handle),
    .file_id        (file_id),
    .row            (row),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .done           (done),
    .status         (status),
    .held           (held),
    .pending        (pending),
    .fail_count     (fail_count),
    .results_seen   (results_seen),
    .conflicts_seen (conflicts_seen),
    .full_seen      (full_seen),
    .held_seen      (held_seen)
  );

  // Watchdog: any request or result transfer restarts the count. The clear
  // pass after reset and the longest request plus sender gap fit well inside.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one request and hold it until the block takes it. Start stays
  // high into the next call unless that call opens an idle gap first, so it
  // never drops and rises within the same step. The gap is counted in
  // cycles where the block is ready, so it always shows at the input.
  task automatic send_request(input logic [1:0] req_mode, input logic [HANDLE_W-1:0] req_handle,
                              input logic [FILE_W-1:0] req_file, input logic [ROW_W-1:0] req_row);
    int gap;
    gap = 0;
    // lengthen the idle gap while each draw falls under 31 of 100, up to GAP_MAX
    if (!no_idle) begin
      while (gap < GAP_MAX && $urandom_range(0, 99) < 31) gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      @(posedge clk);
      while (busy) @(posedge clk);
      repeat (gap - 1) @(posedge clk);
    end
    start   <= 1'b1;
    mode    <= req_mode;
    handle  <= req_handle;
    file_id <= req_file;
    row     <= req_row;
    // busy is read before this edge's updates land: low here means transfer
    do @(posedge clk); while (busy);
    case (req_mode)
      MODE_ACQUIRE: acquire_sent++;
      MODE_RELEASE: release_sent++;
      MODE_QUERY:   query_sent++;
      default:      unused_sent++;
    endcase
  endtask

  // Drop start and wait for every outstanding result. Step one edge first so
  // the scoreboard's count already includes the request just taken.
  task automatic wait_quiet;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_compat(input logic value);
    wait_quiet();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // One phase of random requests. A small crew of handles fights over the
  // pool keys so that owns, conflicts and a full table all come up; the rest
  // is fresh random keys and corner keys that mostly miss.
  task automatic run_phase(input int kind, input int count);
    logic [HANDLE_W-1:0] crew [3];
    logic [1:0]          m;
    logic [HANDLE_W-1:0] h;
    logic [FILE_W-1:0]   f;
    logic [ROW_W-1:0]    r;
    int                  acquire_pct;
    int                  release_pct;
    int                  pick;
    int                  k;
    foreach (crew[i]) crew[i] = HANDLE_W'($urandom_range(0, 63));
    case (kind)
      KIND_FILL:     begin acquire_pct = 62; release_pct = 12; end
      KIND_BALANCED: begin acquire_pct = 40; release_pct = 35; end
      default:       begin acquire_pct = 15; release_pct = 65; end
    endcase
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < acquire_pct) m = MODE_ACQUIRE;
      else if (pick < acquire_pct + release_pct) m = MODE_RELEASE;
      else if ($urandom_range(0, 5) == 0) m = MODE_UNUSED;
      else m = MODE_QUERY;
      if ($urandom_range(0, 99) < 80) h = crew[$urandom_range(0, 2)];
      else h = HANDLE_W'($urandom_range(0, 63));
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        k = $urandom_range(0, KEY_POOL - 1);
        f = pool_file[k];
        r = pool_row[k];
      end else if (pick < 95) begin
        f = FILE_W'($urandom_range(0, 63));
        r = {16'($urandom), 32'($urandom)};
      end else begin
        f = $urandom_range(0, 1) ? FILE_TOP : '0;
        r = $urandom_range(0, 1) ? ROW_ALL : ROW_ZERO;
      end
      send_request(m, h, f, r);
    end
  endtask

  initial begin : stimulus
    logic [FILE_W-1:0] file_a;
    logic [ROW_W-1:0]  base [ROW_BASES];

    // Hold reset, then let the clear pass run out.
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);
    write_compat(1'b0);

    // Strict mode: own lock, foreign lock, the mode 3 query, a match that
    // sits behind a freed slot, reuse of the lowest hole, release of nothing.
    send_request(MODE_QUERY,   '0,         '0,       ROW_ZERO);
    send_request(MODE_ACQUIRE, '0,         '0,       ROW_ZERO);
    send_request(MODE_QUERY,   '0,         '0,       ROW_ZERO);
    send_request(MODE_ACQUIRE, '0,         '0,       ROW_ZERO);
    send_request(MODE_QUERY,   HANDLE_TOP, '0,       ROW_ZERO);
    send_request(MODE_ACQUIRE, HANDLE_TOP, '0,       ROW_ZERO);
    send_request(MODE_RELEASE, HANDLE_TOP, '0,       ROW_ZERO);
    send_request(MODE_ACQUIRE, HANDLE_TOP, FILE_TOP, ROW_ALL);
    send_request(MODE_ACQUIRE, HANDLE_TOP, '0,       ROW_ALL);
    send_request(MODE_UNUSED,  HANDLE_TOP, FILE_TOP, ROW_ALL);
    send_request(MODE_ACQUIRE, '0,         '0,       ROW_W'(1));
    send_request(MODE_RELEASE, HANDLE_TOP, FILE_TOP, ROW_ALL);
    send_request(MODE_QUERY,   HANDLE_TOP, '0,       ROW_ALL);
    send_request(MODE_ACQUIRE, 6'd5,       6'd21,    ROW_ALT0);
    send_request(MODE_RELEASE, '0,         '0,       ROW_ZERO);
    send_request(MODE_RELEASE, '0,         '0,       ROW_ZERO);

    // Compat mode: foreign locks neither block an acquire nor survive a
    // release by another handle.
    write_compat(1'b1);
    send_request(MODE_ACQUIRE, 6'd42, 6'd21, ROW_ALT1);
    send_request(MODE_ACQUIRE, 6'd9,  6'd21, ROW_ALT1);
    send_request(MODE_QUERY,   6'd9,  6'd21, ROW_ALT1);
    send_request(MODE_RELEASE, 6'd9,  6'd21, ROW_ALT1);
    send_request(MODE_QUERY,   6'd42, 6'd21, ROW_ALT1);
    send_request(MODE_RELEASE, 6'd9,  6'd21, ROW_ALT0);

    // Build the shared key pool; odd bases differ from their neighbor in one
    // bit so near misses get compared too.
    file_a = FILE_W'($urandom_range(0, 63));
    for (int i = 0; i < ROW_BASES; i++) begin
      if (i % 2 == 1) base[i] = base[i-1] ^ (ROW_W'(1) << $urandom_range(0, ROW_W - 1));
      else base[i] = {16'($urandom), 32'($urandom)};
    end
    for (int i = 0; i < KEY_POOL; i++) begin
      pool_row[i]  = base[i % ROW_BASES];
      pool_file[i] = (i < ROW_BASES) ? file_a : file_a ^ FILE_W'($urandom_range(1, 63));
    end

    // Walk every phase kind under both compat settings; one phase runs with
    // the sender never idling.
    for (int p = 0; p < PHASES; p++) begin
      write_compat(p % 2 == 1);
      no_idle = (p == 4);
      run_phase(p % 3, ITEMS_PER_PHASE);
    end
    no_idle = 1'b0;

    // Drain: all results in, then a request's worth of quiet cycles.
    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d acquire, %0d release, %0d query, %0d unused mode",
             acquire_sent + release_sent + query_sent + unused_sent,
             acquire_sent, release_sent, query_sent, unused_sent);
    $display("Checked %0d results: %0d held, %0d conflicts, %0d table full, compat on and off",
             results_seen, held_seen, conflicts_seen, full_seen);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
